// ===== sv/sbcd_pkg.sv =====
// shared constants, types and helpers for the sprite box collision detector
package sbcd_pkg;

  localparam int SPRITE_COUNT = 8;
  localparam int ROW_W        = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int IDX_IN_W     = 3;
  localparam int POS_W        = 16;
  localparam int BOX_W        = 8;
  localparam int MASK_W       = 8;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 8;
  localparam logic [BOX_W-1:0] BOX_RESET = 8'd24;

  typedef struct packed {
    logic             write;
    logic             scan;
    logic             load_out;
    logic [ROW_W-1:0] row;
  } sbcd_cmd_t;

  // fold the 3-bit input index onto the table
  function automatic logic [ROW_W-1:0] fold_index(input logic [IDX_IN_W-1:0] v);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int k = 0; k < (1 << IDX_IN_W); k++) begin
      if (v == IDX_IN_W'(k)) r = ROW_W'(k % SPRITE_COUNT);
    end
    return r;
  endfunction

  // only the low eight sprites reach the result
  function automatic logic [MASK_W-1:0] trim_mask(input logic [SPRITE_COUNT-1:0] m);
    logic [MASK_W-1:0] r;
    r = '0;
    for (int k = 0; k < MASK_W; k++) begin
      if (k < SPRITE_COUNT) r[k] = m[k];
    end
    return r;
  endfunction

endpackage

// ===== sv/sbcd_ctrl.sv =====
// controller: input acceptance, row scan sequencing and output register handshake
module sbcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sbcd_pkg::sbcd_cmd_t cmd
);
  import sbcd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]       state, state_next;
  logic [ROW_W-1:0] row, row_next;
  logic             out_valid_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    row_next     = row;
    cmd.write    = 1'b0;
    cmd.scan     = 1'b0;
    cmd.load_out = 1'b0;
    cmd.row      = row;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.write  = 1'b1;
          row_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (row == ROW_W'(SPRITE_COUNT - 1)) begin
          state_next = ST_HOLD;
        end else begin
          row_next = row + 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/sbcd_datapath.sv =====
// datapath: sprite table, box size register, row comparators and result register
module sbcd_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  sbcd_pkg::sbcd_cmd_t          cmd,
  input  logic [sbcd_pkg::IDX_IN_W-1:0] sprite_index,
  input  logic signed [sbcd_pkg::POS_W-1:0] x_position,
  input  logic signed [sbcd_pkg::POS_W-1:0] y_position,
  input  logic                         visible,
  input  logic                         cfg_write,
  input  logic [sbcd_pkg::BOX_W-1:0]   cfg_box,
  output logic [sbcd_pkg::MASK_W-1:0]  collision_mask
);
  import sbcd_pkg::*;

  logic signed [POS_W-1:0] sx [SPRITE_COUNT];
  logic signed [POS_W-1:0] sy [SPRITE_COUNT];
  logic [SPRITE_COUNT-1:0] shown;
  logic [SPRITE_COUNT-1:0] scan_mask;
  logic [BOX_W-1:0]        box_size;
  logic [ROW_W-1:0]        wr_row;
  logic [SPRITE_COUNT-1:0] hit;
  logic                    row_hit;

  assign wr_row = fold_index(sprite_index);

  // compare the scanned row against every other entry, 17-bit exact distance
  always_comb begin
    logic signed [POS_W:0] dx, dy;
    logic [POS_W:0]        ax, ay;
    for (int j = 0; j < SPRITE_COUNT; j++) begin
      dx = {sx[cmd.row][POS_W-1], sx[cmd.row]} - {sx[j][POS_W-1], sx[j]};
      dy = {sy[cmd.row][POS_W-1], sy[cmd.row]} - {sy[j][POS_W-1], sy[j]};
      ax = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
      ay = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
      hit[j] = shown[j] && (cmd.row != ROW_W'(j)) &&
               (ax < (POS_W+1)'(box_size)) && (ay < (POS_W+1)'(box_size));
    end
  end

  assign row_hit = shown[cmd.row] && (|hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      shown    <= '0;
      box_size <= BOX_RESET;
    end else begin
      if (cfg_write) box_size <= cfg_box;
      if (cmd.write) shown[wr_row] <= visible;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      sx[wr_row] <= x_position;
      sy[wr_row] <= y_position;
      scan_mask  <= '0;
    end else if (cmd.scan) begin
      scan_mask[cmd.row] <= row_hit;
    end
    if (cmd.load_out) collision_mask <= trim_mask(scan_mask);
  end

endmodule

// ===== sv/sprite_box_collision_detector_top.sv =====
// Sprite box collision detector: holds position and shown flag of eight sprites; each
// transfer rewrites one sprite and returns the collision mask of the updated table.
// On acceptance the table is written, then one row of comparators checks one sprite against all
// others per cycle (state SCAN), then state HOLD loads the output register; input is taken
// again only in IDLE, after that load. A new item is accepted while the previous result
// still waits in the output register; if that result is still not taken when the next scan
// ends, the block holds and stops taking input.
// box_size writes are taken at any time via the cfg channel, but should only be made while
// no item is in flight.
module sprite_box_collision_detector_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // sprite_index[2:0], x_position[18:3], y_position[34:19],
                                 // visible[35], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // collision_mask[7:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // box_size
);
  import sbcd_pkg::*;

  sbcd_cmd_t cmd;

  assign cfg_ready = 1'b1;

  sbcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  sbcd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sprite_index   (s_tdata[2:0]),
    .x_position     (s_tdata[18:3]),
    .y_position     (s_tdata[34:19]),
    .visible        (s_tdata[35]),
    .cfg_write      (cfg_valid),
    .cfg_box        (cfg_data),
    .collision_mask (m_tdata)
  );

endmodule

// ===== bench/sbcd_checker.sv =====
// checker for the sprite box collision detector: tracks the sprite table and compares masks
module sbcd_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [sbcd_pkg::IN_DATA_W-1:0]  s_tdata,   // sprite_index, x_position, y_position,
                                                     // visible
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [sbcd_pkg::OUT_DATA_W-1:0] m_tdata,   // collision_mask
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sbcd_pkg::BOX_W-1:0]      cfg_data,  // box_size
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbcd_pkg::*;

  localparam int X_LSB   = IDX_IN_W;
  localparam int Y_LSB   = X_LSB + POS_W;
  localparam int VIS_BIT = Y_LSB + POS_W;

  logic signed [POS_W-1:0] sprite_xpos [SPRITE_COUNT];
  logic signed [POS_W-1:0] sprite_ypos [SPRITE_COUNT];
  logic [SPRITE_COUNT-1:0] shown;
  logic [BOX_W-1:0]        box_size;
  logic [MASK_W-1:0]       mask_queue [$];

  // pairwise overlap over the whole table, distances taken at full precision
  function automatic logic [MASK_W-1:0] overlap_mask();
    int dx;
    int dy;
    logic [31:0] hits;
    hits = '0;
    for (int i = 0; i < SPRITE_COUNT; i++) begin
      for (int j = i + 1; j < SPRITE_COUNT; j++) begin
        dx = int'(sprite_xpos[i]) - int'(sprite_xpos[j]);
        dy = int'(sprite_ypos[i]) - int'(sprite_ypos[j]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (shown[i] && shown[j] && dx < int'(box_size) && dy < int'(box_size)) begin
          hits[i] = 1'b1;
          hits[j] = 1'b1;
        end
      end
    end
    return hits[MASK_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [IDX_IN_W-1:0] raw_idx;
    int                  row;
    logic [MASK_W-1:0]   want;
    if (rst) begin
      for (int k = 0; k < SPRITE_COUNT; k++) begin
        sprite_xpos[k] = '0;
        sprite_ypos[k] = '0;
      end
      shown    = '0;
      box_size = BOX_RESET;
      mask_queue.delete();
      errors   = 0;
    end else begin
      // results leave before this edge's input can produce one
      if (m_tvalid && m_tready) begin
        if (mask_queue.size() == 0) begin
          $error("collision_mask: transfer with nothing expected, actual %h", m_tdata);
          errors++;
        end else begin
          want = mask_queue.pop_front();
          if (m_tdata !== want) begin
            $error("collision_mask: expected %h, actual %h", want, m_tdata);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) box_size = cfg_data;
      if (s_tvalid && s_tready) begin
        raw_idx               = s_tdata[IDX_IN_W-1:0];
        row                   = int'(raw_idx) % SPRITE_COUNT;
        sprite_xpos[row]      = s_tdata[X_LSB +: POS_W];
        sprite_ypos[row]      = s_tdata[Y_LSB +: POS_W];
        shown[row]            = s_tdata[VIS_BIT];
        mask_queue.push_back(overlap_mask());
      end
    end
    pending = mask_queue.size();
  end

endmodule

// ===== bench/tb_sprite_box_collision_detector_top.sv =====
// testbench top for the sprite box collision detector: clock, reset, stimulus and verdict
module tb_sprite_box_collision_detector_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbcd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 2 * SPRITE_COUNT + 4;
  localparam int PHASE_ITEMS  = 200;
  localparam int STALL_AT     = 300;
  localparam int STALL_CYCLES = 400;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // sprite_index, x_position, y_position, visible
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // collision_mask
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [BOX_W-1:0]      cfg_data  = '0;   // box_size

  int               errors;
  int               pending;
  int               cycle_count = 0;
  int               items_sent  = 0;
  bit               steady      = 1'b0;
  logic [BOX_W-1:0] box_now     = BOX_RESET;
  int               base_x      = 0;
  int               base_y      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_box_collision_detector_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sbcd_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_sprite_box_collision_detector_top: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic send_sprite(input int idx, input int x, input int y, input bit vis);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({vis, y[POS_W-1:0], x[POS_W-1:0], idx[IDX_IN_W-1:0]});
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // stop offering and let the block go quiet before touching box_size
  task automatic drain();
    s_tvalid <= 1'b0;
    // let the checker count the last transfer before waiting on pending
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_box(input logic [BOX_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    box_now = v;
  endtask

  // mostly sprites clustered within reach of each other, some anywhere, some at the edges
  task automatic random_sprite();
    int roll;
    int spread;
    int x;
    int y;
    roll   = $urandom_range(0, 99);
    spread = 2 * int'(box_now) + 2;
    if (roll < 70) begin
      x = clamp16(base_x + int'($urandom_range(0, 2 * spread)) - spread);
      y = clamp16(base_y + int'($urandom_range(0, 2 * spread)) - spread);
    end else if (roll < 85) begin
      x = int'($urandom_range(0, 65535)) - 32768;
      y = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      x = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, spread))
                               : -32768 + int'($urandom_range(0, spread));
      y = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, spread))
                               : -32768 + int'($urandom_range(0, spread));
    end
    send_sprite($urandom_range(0, SPRITE_COUNT - 1), x, y, $urandom_range(0, 3) != 0);
  endtask

  // result side: random ready runs and gaps, plus one long hold-off to back the block up
  initial begin : result_sink
    int  span;
    int  roll;
    bit  held;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held && items_sent >= STALL_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      roll = $urandom_range(0, 99);
      span = (roll < 80) ? $urandom_range(1, 8) : $urandom_range(20, 100);
      m_tready <= 1'b1;
      repeat (span) @(posedge clk);
      roll = $urandom_range(0, 99);
      if (roll >= 50) begin
        span = (roll < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        m_tready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [BOX_W-1:0] phase_box [7];
    phase_box = '{8'd24, 8'd1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
    for (int p = 3; p < 7; p++) phase_box[p] = BOX_W'($urandom_range(2, 254));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset box size: touching at one less than the box, apart at exactly the box
    send_sprite(0, 0, 0, 1'b1);
    send_sprite(1, 23, -23, 1'b1);
    send_sprite(1, 24, 0, 1'b1);
    send_sprite(2, -23, 23, 1'b1);
    send_sprite(2, -23, 23, 1'b0);
    // opposite corners must not meet through a 16-bit wrap
    send_sprite(3, 32767, 32767, 1'b1);
    send_sprite(4, -32768, -32768, 1'b1);
    send_sprite(5, 32767, -32768, 1'b1);
    send_sprite(6, -32768, 32767, 1'b1);
    send_sprite(7, 32760, 32767, 1'b1);
    send_sprite(7, 32760, 32767, 1'b0);
    send_sprite(2, 0, 24, 1'b1);
    send_sprite(2, 0, 23, 1'b1);
    drain();

    // smallest box: only identical positions overlap
    set_box(8'd1);
    send_sprite(0, 5, 5, 1'b1);
    send_sprite(1, 5, 5, 1'b1);
    send_sprite(1, 6, 5, 1'b1);
    send_sprite(1, 5, 4, 1'b1);
    drain();

    // largest box
    set_box(8'd255);
    send_sprite(2, 259, -249, 1'b1);
    send_sprite(3, 260, 5, 1'b1);
    send_sprite(4, 5, 5, 1'b0);
    send_sprite(5, -32768, -32768, 1'b1);
    send_sprite(6, -32513, -32513, 1'b1);
    send_sprite(6, -32514, -32514, 1'b1);
    drain();

    for (int p = 0; p < 7; p++) begin
      set_box(phase_box[p]);
      steady = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          base_x = int'($urandom_range(0, 65535)) - 32768;
          base_y = int'($urandom_range(0, 65535)) - 32768;
        end
        random_sprite();
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_sprite_box_collision_detector_top: PASS");
    end else begin
      $display("tb_sprite_box_collision_detector_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sbcd_pkg.sv
sv/sbcd_ctrl.sv
sv/sbcd_datapath.sv
sv/sprite_box_collision_detector_top.sv
bench/sbcd_checker.sv
bench/tb_sprite_box_collision_detector_top.sv
